/* sv/wsstd_pkg.sv */
package wsstd_pkg;

  // Input word field widths
  localparam int RAW_BITS     = 12;
  localparam int CHAN_BITS    = 3;

  // Result word field widths
  localparam int DEV_BITS     = 16;
  localparam int WCOUNT_BITS  = 10;
  localparam logic [WCOUNT_BITS-1:0] WCOUNT_MAX = '1;

  // Fraction scaling of the variance before the root: 2^8 gives 4 fraction bits
  localparam int FRAC_SHIFT   = 8;

  // Configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_SELECT = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPORT_ENABLE  = 1'd1;

  // Parameter defaults
  localparam int MAX_WINDOW_DEFAULT  = 800;
  localparam int SAMPLE_BITS_DEFAULT = 12;

endpackage

/* sv/windowed_sample_stddev.sv */
// Channel  Direction  Handshake               Payload
// cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
// in       in         in_valid / in_ready     entry_valid, entry_channel, raw_sample, frame_end
// out      out        out_valid / out_ready   deviation_q4, window_count
//
// An entry that does not close a window is accepted in IDLE, then ACC updates the sums.
// A closing entry with a report then runs NN, NSQ, SSQ, DIV and SQRT on the one shared
// add/subtract unit, and waits in DONE to hand the result on.
// in_ready is high only in the idle state; cfg_ready is always high.
// A finished result waits in the output register; the next word is taken meanwhile, and
// only a second result stalls until the first one is taken.
// rst is synchronous and clears control state, accumulators and configuration.
module windowed_sample_stddev #(
  parameter int MAX_WINDOW  = wsstd_pkg::MAX_WINDOW_DEFAULT,
  parameter int SAMPLE_BITS = wsstd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wsstd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wsstd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input words
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 entry_valid,
  input  logic [wsstd_pkg::CHAN_BITS-1:0]      entry_channel,
  input  logic [wsstd_pkg::RAW_BITS-1:0]       raw_sample,
  input  logic                                 frame_end,
  // result words
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wsstd_pkg::DEV_BITS-1:0]       deviation_q4,
  output logic [wsstd_pkg::WCOUNT_BITS-1:0]    window_count
);

  // Sample bits actually used: the raw field caps them.
  localparam int SW   = (SAMPLE_BITS < wsstd_pkg::RAW_BITS) ? SAMPLE_BITS
                                                            : wsstd_pkg::RAW_BITS;
  localparam int CW   = $clog2(MAX_WINDOW + 1);        // kept count
  localparam int SUMW = CW + SW;                       // running sum
  localparam int SQW  = CW + 2 * SW;                   // running square sum
  localparam int DW   = 2 * CW + 2 * SW;               // n*sumsq - sum^2, shared unit width
  localparam int NNW  = 2 * CW;                        // n*n
  localparam int NW   = DW + wsstd_pkg::FRAC_SHIFT;    // scaled dividend / quotient
  localparam int QW   = 2 * SW + wsstd_pkg::FRAC_SHIFT; // bound on the scaled variance
  localparam int RW   = QW / 2;                        // root width
  localparam int CNTW = $clog2(NW);

  typedef enum logic [2:0] {
    IDLE,
    ACC,
    NN,
    NSQ,
    SSQ,
    DIV,
    SQRT,
    DONE
  } state_t;

  state_t state;
  logic [CNTW-1:0] cnt;

  // configuration
  logic [wsstd_pkg::CHAN_BITS-1:0] channel_select;
  logic                            report_enable;

  // accumulators
  logic [CW-1:0]   kept_count;
  logic [SUMW-1:0] running_sum;
  logic [SQW-1:0]  running_square_sum;

  // held input word
  logic                            it_valid;
  logic [wsstd_pkg::CHAN_BITS-1:0] it_chan;
  logic [SW-1:0]                   it_sample;
  logic                            it_fend;

  // iteration registers
  logic [DW-1:0]   acc;
  logic [DW-1:0]   mul_x;
  logic [SUMW-1:0] mul_y;
  logic [NNW-1:0]  nn;
  logic [NW-1:0]   num;
  logic [NNW-1:0]  rem;
  logic [QW-1:0]   rad;
  logic [RW+1:0]   srem;
  logic [RW-1:0]   root;

  // combinational
  logic            keep;
  logic [2*SW-1:0] sq_term;
  logic [CW-1:0]   kept_next;
  logic [SUMW-1:0] sum_next;
  logic [SQW-1:0]  sqsum_next;
  logic [NNW:0]    rem_shift;
  logic [RW+3:0]   sq_shift;
  logic [RW+1:0]   trial;
  logic [DW-1:0]   unit_a;
  logic [DW-1:0]   unit_b;
  logic            unit_sub;
  logic [DW:0]     unit_sum;
  logic [DW-1:0]   unit_res;
  logic            unit_ge;
  logic            out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);
  assign out_free  = !out_valid || out_ready;

  // Keep the held entry only if valid, on the selected channel, and the window has room.
  assign keep       = it_valid && (it_chan == channel_select) &&
                      (kept_count < CW'(MAX_WINDOW));
  assign sq_term    = it_sample * it_sample;
  assign kept_next  = keep ? kept_count + CW'(1) : kept_count;
  assign sum_next   = keep ? running_sum + SUMW'(it_sample) : running_sum;
  assign sqsum_next = keep ? running_square_sum + SQW'(sq_term) : running_square_sum;

  // Long division brings in one dividend bit; the root brings in two radicand bits.
  assign rem_shift = {rem, num[NW-1]};
  assign sq_shift  = {srem, rad[QW-1:QW-2]};
  assign trial     = {root, 2'b01};

  // Shared add/subtract unit: multiply by shift-add, subtract s*s, divide, square root.
  always_comb begin
    unit_a   = '0;
    unit_b   = '0;
    unit_sub = 1'b0;
    unique case (state)
      NN, NSQ: begin
        unit_a = acc;
        unit_b = mul_y[0] ? mul_x : '0;
      end
      SSQ: begin
        unit_a   = acc;
        unit_b   = mul_y[0] ? mul_x : '0;
        unit_sub = 1'b1;
      end
      DIV: begin
        unit_a   = DW'(rem_shift);
        unit_b   = DW'(nn);
        unit_sub = 1'b1;
      end
      SQRT: begin
        unit_a   = DW'(sq_shift);
        unit_b   = DW'(trial);
        unit_sub = 1'b1;
      end
      IDLE, ACC, DONE: begin
        unit_a = '0;
      end
    endcase
    unit_sum = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)} + (DW + 1)'(unit_sub);
    unit_res = unit_sum[DW-1:0];
    unit_ge  = unit_sum[DW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= IDLE;
      cnt                <= '0;
      channel_select     <= '0;
      report_enable      <= 1'b0;
      kept_count         <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      out_valid          <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          wsstd_pkg::CFG_CHANNEL_SELECT: channel_select <= cfg_data;
          wsstd_pkg::CFG_REPORT_ENABLE:  report_enable  <= cfg_data[0];
        endcase
      end

      // raise the result once the output register is free, drop it once taken
      if (state == DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_valid) begin
            it_valid  <= entry_valid;
            it_chan   <= entry_channel;
            it_sample <= raw_sample[SW-1:0];
            it_fend   <= frame_end;
            state     <= ACC;
          end
        end

        ACC: begin
          if (!it_fend) begin
            kept_count         <= kept_next;
            running_sum        <= sum_next;
            running_square_sum <= sqsum_next;
            state              <= IDLE;
          end else if (kept_next != '0 && report_enable) begin
            kept_count         <= kept_next;
            running_sum        <= sum_next;
            running_square_sum <= sqsum_next;
            // start n*n
            acc   <= '0;
            mul_x <= DW'(kept_next);
            mul_y <= SUMW'(kept_next);
            cnt   <= CNTW'(CW - 1);
            state <= NN;
          end else begin
            // empty window or reporting off: just clear
            kept_count         <= '0;
            running_sum        <= '0;
            running_square_sum <= '0;
            state              <= IDLE;
          end
        end

        NN, NSQ, SSQ: begin
          if (cnt == '0) begin
            if (state == NN) begin
              nn    <= unit_res[NNW-1:0];
              acc   <= '0;
              mul_x <= DW'(running_square_sum);
              mul_y <= SUMW'(kept_count);
              cnt   <= CNTW'(CW - 1);
              state <= NSQ;
            end else if (state == NSQ) begin
              acc   <= unit_res;
              mul_x <= DW'(running_sum);
              mul_y <= running_sum;
              cnt   <= CNTW'(SUMW - 1);
              state <= SSQ;
            end else begin
              // dividend is the difference scaled by 256
              num   <= {unit_res, wsstd_pkg::FRAC_SHIFT'(0)};
              rem   <= '0;
              cnt   <= CNTW'(NW - 1);
              state <= DIV;
            end
          end else begin
            acc   <= unit_res;
            mul_x <= {mul_x[DW-2:0], 1'b0};
            mul_y <= {1'b0, mul_y[SUMW-1:1]};
            cnt   <= cnt - CNTW'(1);
          end
        end

        DIV: begin
          rem <= unit_ge ? unit_res[NNW-1:0] : rem_shift[NNW-1:0];
          num <= {num[NW-2:0], unit_ge};
          if (cnt == '0) begin
            rad   <= {num[QW-2:0], unit_ge};
            srem  <= '0;
            root  <= '0;
            cnt   <= CNTW'(RW - 1);
            state <= SQRT;
          end else begin
            cnt <= cnt - CNTW'(1);
          end
        end

        SQRT: begin
          srem <= unit_ge ? unit_res[RW+1:0] : sq_shift[RW+1:0];
          root <= {root[RW-2:0], unit_ge};
          rad  <= {rad[QW-3:0], 2'b00};
          cnt  <= cnt - CNTW'(1);
          if (cnt == '0) begin
            state <= DONE;
          end
        end

        DONE: begin
          // hold until the output register is free
          if (out_free) begin
            deviation_q4       <= wsstd_pkg::DEV_BITS'(root);
            window_count       <= (32'(kept_count) > 32'(wsstd_pkg::WCOUNT_MAX))
                                  ? wsstd_pkg::WCOUNT_MAX
                                  : wsstd_pkg::WCOUNT_BITS'(kept_count);
            kept_count         <= '0;
            running_sum        <= '0;
            running_square_sum <= '0;
            state              <= IDLE;
          end
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CW'(MAX_WINDOW))
    else $error("kept count passed the window size");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_count != '0)
    else $error("result from an empty window");

  a_accept_to_acc: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ACC)
    else $error("accepted word not handled in the next cycle");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == DIV |-> rem < nn)
    else $error("division remainder not below divisor");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    state == SQRT |-> srem <= (RW + 2)'({root, 1'b0}))
    else $error("root remainder out of bound");

endmodule

/* bench/wsstd_checker.sv */
module wsstd_checker
  import wsstd_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEFAULT,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      entry_valid,
  input  logic [CHAN_BITS-1:0]      entry_channel,
  input  logic [RAW_BITS-1:0]       raw_sample,
  input  logic                      frame_end,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [DEV_BITS-1:0]       deviation_q4,
  input  logic [WCOUNT_BITS-1:0]    window_count,
  output int                        mismatches,
  output int                        levels_due
);

  typedef struct packed {
    logic [DEV_BITS-1:0]    deviation;
    logic [WCOUNT_BITS-1:0] count;
  } level_t;

  level_t               predicted_levels[$];
  logic [CHAN_BITS-1:0] sel_channel;
  logic                 reporting;
  logic [63:0]          window_fill;
  logic [63:0]          window_sum;
  logic [63:0]          window_square_sum;
  int                   errors = 0;

  // Largest r with r*r <= v; the root of a 64-bit value stays below 2^32.
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] lo, hi, mid;
    lo = 64'd0;
    hi = 64'd1 << 32;
    while (hi - lo > 64'd1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [DEV_BITS-1:0] stddev_q4(input logic [63:0] n,
                                                    input logic [63:0] s,
                                                    input logic [63:0] sq);
    logic [63:0] spread, scaled, root;
    spread = n * sq - s * s;
    scaled = (spread << FRAC_SHIFT) / (n * n);
    root   = floor_root(scaled);
    if ((root >> DEV_BITS) != 64'd0) return '1;
    return root[DEV_BITS-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [63:0] sample;
    level_t      want;
    if (rst) begin
      sel_channel       = '0;
      reporting         = 1'b0;
      window_fill       = 64'd0;
      window_sum        = 64'd0;
      window_square_sum = 64'd0;
      predicted_levels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHANNEL_SELECT: sel_channel = cfg_data[CHAN_BITS-1:0];
          CFG_REPORT_ENABLE:  reporting   = cfg_data[0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        sample = 64'(raw_sample) & ((64'd1 << SAMPLE_BITS) - 64'd1);
        if (entry_valid && entry_channel == sel_channel && window_fill < MAX_WINDOW) begin
          window_fill       = window_fill + 64'd1;
          window_sum        = window_sum + sample;
          window_square_sum = window_square_sum + sample * sample;
        end
        if (frame_end) begin
          if (window_fill != 64'd0 && reporting) begin
            want.deviation = stddev_q4(window_fill, window_sum, window_square_sum);
            want.count     = (window_fill > 64'(WCOUNT_MAX)) ? WCOUNT_MAX
                                                             : window_fill[WCOUNT_BITS-1:0];
            predicted_levels.push_back(want);
          end
          window_fill       = 64'd0;
          window_sum        = 64'd0;
          window_square_sum = 64'd0;
        end
      end

      if (out_valid && out_ready) begin
        if (predicted_levels.size() == 0) begin
          $error("unexpected result word: deviation_q4 %0d window_count %0d",
                 deviation_q4, window_count);
          errors++;
        end else begin
          want = predicted_levels.pop_front();
          if (deviation_q4 !== want.deviation) begin
            $error("deviation_q4 expected %0d actual %0d", want.deviation, deviation_q4);
            errors++;
          end
          if (window_count !== want.count) begin
            $error("window_count expected %0d actual %0d", want.count, window_count);
            errors++;
          end
        end
      end
    end
    mismatches <= errors;
    levels_due <= predicted_levels.size();
  end

endmodule

/* bench/tb_top.sv */
module tb_top;
  import wsstd_pkg::*;

  localparam int MAX_WINDOW  = MAX_WINDOW_DEFAULT;
  localparam int SAMPLE_BITS = SAMPLE_BITS_DEFAULT;

  // Words to send in the random part, ignored entries included.
  localparam int WORD_GOAL    = 1330;
  // Pad after the results drain, before touching the registers or giving the verdict.
  localparam int SETTLE_PAD   = 150;
  // Worst case: every word closing a window, every gap and stall at its longest.
  localparam int CYCLE_LIMIT  = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  logic                      in_valid      = 1'b0;
  logic                      in_ready;
  logic                      entry_valid   = 1'b0;
  logic [CHAN_BITS-1:0]      entry_channel = '0;
  logic [RAW_BITS-1:0]       raw_sample    = '0;
  logic                      frame_end     = 1'b0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [DEV_BITS-1:0]       deviation_q4;
  logic [WCOUNT_BITS-1:0]    window_count;

  int                        mismatches;
  int                        levels_due;

  // Both sides drop their idling while this is set.
  logic                      steady = 1'b0;
  logic [CHAN_BITS-1:0]      cur_channel = '0;
  int                        sent_words  = 0;
  int                        cycles      = 0;

  always #10 clk = ~clk;

  windowed_sample_stddev #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .entry_valid   (entry_valid),
    .entry_channel (entry_channel),
    .raw_sample    (raw_sample),
    .frame_end     (frame_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .deviation_q4  (deviation_q4),
    .window_count  (window_count)
  );

  wsstd_checker #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .entry_valid   (entry_valid),
    .entry_channel (entry_channel),
    .raw_sample    (raw_sample),
    .frame_end     (frame_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .deviation_q4  (deviation_q4),
    .window_count  (window_count),
    .mismatches    (mismatches),
    .levels_due    (levels_due)
  );

  // Result side: stall at odds of 28 in a hundred, never during a steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 28);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one input word and hold it until the block takes it. Leave in_valid
  // high on return so a back-to-back word needs no second assignment in the step.
  task automatic send_word(input logic ev, input logic [CHAN_BITS-1:0] ch,
                           input logic [RAW_BITS-1:0] raw, input logic fe);
    if (!steady && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 28);
    end
    in_valid      <= 1'b1;
    entry_valid   <= ev;
    entry_channel <= ch;
    raw_sample    <= raw;
    frame_end     <= fe;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every predicted level has been taken. Wait on the
  // clock first so the checker has counted a word accepted at this very edge.
  task automatic await_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (levels_due != 0);
  endtask

  // Idle the block: drained results, then room for a dropped report to finish.
  task automatic settle();
    await_results();
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  // Write one register; the caller lowers cfg_valid after the last write.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Program both registers; only bit 0 of the enable write matters, so
  // randomize the upper data bits to exercise the whole field.
  task automatic configure(input logic [CHAN_BITS-1:0] sel, input logic en);
    logic [CFG_DATA_BITS-1:0] en_word;
    en_word    = CFG_DATA_BITS'($urandom);
    en_word[0] = en;
    write_reg(CFG_CHANNEL_SELECT, sel);
    write_reg(CFG_REPORT_ENABLE, en_word);
    cfg_valid   <= 1'b0;
    cur_channel  = sel;
  endtask

  // One read frame: mostly entries for the selected channel, the rest
  // entries for other channels or invalid conversions; frame_end on the last.
  task automatic run_frame(input int len, input int match_pct);
    int                   pick;
    logic                 ev;
    logic [CHAN_BITS-1:0] ch;
    logic [RAW_BITS-1:0]  raw;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < match_pct) begin
        ev = 1'b1;
        ch = cur_channel;
      end else if (pick < match_pct + (100 - match_pct) / 2) begin
        ev = 1'b1;
        ch = cur_channel + CHAN_BITS'($urandom_range(1, 7));
      end else begin
        ev = 1'b0;
        ch = CHAN_BITS'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 8) raw = '0;
      else if (pick < 16) raw = '1;
      else raw = RAW_BITS'($urandom);
      sent_words++;
      send_word(ev, ch, raw, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    configure(3'd5, 1'b1);
    send_word(1'b1, 3'd5, 12'd4095, 1'b1);   // single sample: zero deviation
    send_word(1'b1, 3'd5, 12'd0,    1'b0);   // full-scale pair: widest spread
    send_word(1'b1, 3'd5, 12'd4095, 1'b1);
    send_word(1'b0, 3'd5, 12'd1234, 1'b0);   // empty window: nothing kept
    send_word(1'b1, 3'd2, 12'd77,   1'b0);
    send_word(1'b0, 3'd3, 12'd0,    1'b1);
    send_word(1'b1, 3'd5, 12'd100,  1'b0);   // closing word is itself kept
    send_word(1'b1, 3'd4, 12'd999,  1'b0);
    send_word(1'b1, 3'd5, 12'd300,  1'b1);
    send_word(1'b1, 3'd5, 12'd7,    1'b0);   // closing word is not kept
    send_word(1'b1, 3'd5, 12'd9,    1'b0);
    send_word(1'b0, 3'd5, 12'd11,   1'b1);
    settle();
    configure(3'd5, 1'b0);                   // reporting off: result dropped
    send_word(1'b1, 3'd5, 12'd500,  1'b0);
    send_word(1'b1, 3'd5, 12'd2500, 1'b1);
    settle();
    configure(3'd7, 1'b1);
    send_word(1'b1, 3'd7, 12'd2048, 1'b0);
    send_word(1'b1, 3'd7, 12'd2047, 1'b1);
    settle();

    // Random part: phases of frames under changing register settings.
    for (int phase = 0; sent_words < WORD_GOAL; phase++) begin
      steady <= (phase == 1);
      if (phase == 0) configure(3'd7, 1'b1);
      else if (phase == 1) configure(3'd0, 1'b1);
      else configure(CHAN_BITS'($urandom), (phase % 4) != 2);
      // Overfill the window once so the tail of the frame is ignored.
      if (phase == 1) run_frame(MAX_WINDOW + $urandom_range(5, 25), 100);
      for (int f = 0; f < 8 && sent_words < WORD_GOAL; f++) begin
        len = ($urandom_range(11) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 20);
        run_frame(len, 75);
        if ($urandom_range(9) == 0) await_results();
      end
      settle();
    end

    // settle() above has drained everything and padded past the latency.
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/wsstd_pkg.sv
sv/windowed_sample_stddev.sv
bench/wsstd_checker.sv
bench/tb_top.sv
